/* design/cbff_pkg.sv */
// Shared types and constants for the contiguous first-fit allocator.
// Used by the config block, the allocation engine and the top level.
`default_nettype none

package cbff_pkg;

  localparam int STORE_WORDS_DEF   = 256;
  localparam int TABLE_ENTRIES_DEF = 255;

  localparam int HANDLE_W = 15;
  localparam int SIZE_W   = 9;
  localparam int BS_W     = 9;
  localparam int START_W  = 8;
  localparam int WORD_W   = 16;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 9'd8;

  // register index is paddr[2]
  localparam logic REG_BLOCK_SIZE = 1'b0;

  typedef enum logic [1:0] {
    STAT_PLACED     = 2'd0,
    STAT_DISK_FULL  = 2'd1,
    STAT_TABLE_FULL = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [START_W-1:0]   start_word;
    logic [SIZE_W-1:0]    blocks_used;
  } res_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [START_W-1:0]   start;
    logic [SIZE_W-1:0]    size;
  } tab_entry_t;

endpackage

`default_nettype wire

/* design/cbff_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module cbff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* design/cbff_cfg.sv */
// APB-style configuration register: block size.
// Depends on cbff_pkg.
`default_nettype none

module cbff_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbff_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cbff_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cbff_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output logic      [cbff_pkg::BS_W-1:0]     block_size
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= cbff_pkg::BLOCK_SIZE_RST;
    end else if (wr_en && paddr[2] == cbff_pkg::REG_BLOCK_SIZE) begin
      block_size <= pwdata[cbff_pkg::BS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cbff_pkg::REG_BLOCK_SIZE) begin
      prdata = {{(cbff_pkg::PDATA_W-cbff_pkg::BS_W){1'b0}}, block_size};
    end
  end

endmodule

`default_nettype wire

/* design/cbff_engine.sv */
// Allocation sequencer: clearing pass, first-fit scan, word fill, table commit.
// Drives the word store and file table RAM ports. Depends on cbff_pkg.
`default_nettype none

module cbff_engine #(
  parameter int STORE_WORDS   = cbff_pkg::STORE_WORDS_DEF,
  parameter int TABLE_ENTRIES = cbff_pkg::TABLE_ENTRIES_DEF,
  localparam int AW  = $clog2(STORE_WORDS),
  localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [cbff_pkg::BS_W-1:0]      block_size,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cbff_pkg::HANDLE_W-1:0]  file_handle,
  input  wire logic [cbff_pkg::SIZE_W-1:0]    file_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [1:0]                     status,
  output logic      [cbff_pkg::START_W-1:0]   start_word,
  output logic      [cbff_pkg::SIZE_W-1:0]    blocks_used,
  output logic                                mem_we,
  output logic      [AW-1:0]                  mem_addr,
  output logic      [cbff_pkg::WORD_W-1:0]    mem_wdata,
  input  wire logic [cbff_pkg::WORD_W-1:0]    mem_rdata,
  output logic                                tab_we,
  output logic      [TAW-1:0]                 tab_addr,
  output cbff_pkg::tab_entry_t                tab_wdata
);

  // offsets reach past the store by up to one block or one file
  localparam int CW  = $clog2(STORE_WORDS + 512);
  localparam int FCW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CAND, S_SCAN, S_SKIP, S_WRITE, S_COMMIT, S_RESULT
  } state_t;

  state_t                          state;
  logic [CW-1:0]                   c;      // candidate start
  logic [CW-1:0]                   w;      // scanned word, later the busy word
  logic [CW-1:0]                   wp;     // clear / fill pointer
  logic [cbff_pkg::WORD_W-1:0]     val;
  logic [cbff_pkg::HANDLE_W-1:0]   handle;
  logic [cbff_pkg::SIZE_W-1:0]     size;
  logic [cbff_pkg::BS_W-1:0]       bs;
  logic [cbff_pkg::BS_W-1:0]       kcnt;
  logic [cbff_pkg::SIZE_W-1:0]     blocks;
  logic [FCW-1:0]                  file_count;
  cbff_pkg::res_t                  res;

  logic [CW-1:0] c_bs, c_end, w_inc, wp_inc, store_end;

  assign c_bs      = c + CW'(bs);
  assign c_end     = c + CW'(size);
  assign w_inc     = w + 1'b1;
  assign wp_inc    = wp + 1'b1;
  assign store_end = CW'(STORE_WORDS);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = c[AW-1:0];
    mem_wdata = val;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = wp[AW-1:0];
        mem_wdata = '0;
      end
      S_SCAN:  mem_addr = w_inc[AW-1:0];
      S_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = wp[AW-1:0];
      end
      default: mem_addr = c[AW-1:0];
    endcase
  end

  assign tab_we    = (state == S_COMMIT);
  assign tab_addr  = file_count[TAW-1:0];
  assign tab_wdata = '{handle: handle, start: c[cbff_pkg::START_W-1:0], size: size};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      wp         <= '0;
      file_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          wp <= wp_inc;
          if (wp == CW'(STORE_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            handle <= file_handle;
            size   <= file_size;
            bs     <= (block_size == '0) ? cbff_pkg::BS_W'(1) : block_size;
            val    <= {1'b0, file_handle};
            kcnt   <= (block_size == '0) ? cbff_pkg::BS_W'(1) : block_size;
            blocks <= '0;
            c      <= '0;
            if (file_count >= FCW'(TABLE_ENTRIES)) begin
              res   <= '{status: cbff_pkg::STAT_TABLE_FULL, start_word: '0,
                         blocks_used: '0};
              state <= S_RESULT;
            end else begin
              state <= S_CAND;
            end
          end
        end
        S_CAND: begin
          // a run past the end here fails for every later start too
          if (c_bs > store_end || c_end > store_end) begin
            res   <= '{status: cbff_pkg::STAT_DISK_FULL, start_word: '0,
                       blocks_used: '0};
            state <= S_RESULT;
          end else if (size == '0) begin
            state <= S_COMMIT;
          end else begin
            w     <= c;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_rdata != '0) begin
            state <= S_SKIP;
          end else if (w_inc == c_end) begin
            wp    <= c;
            state <= S_WRITE;
          end else begin
            w <= w_inc;
          end
        end
        S_SKIP: begin
          // starts at or below the busy word would cover it
          c <= c_bs;
          if (c_bs > w) begin
            state <= S_CAND;
          end
        end
        S_WRITE: begin
          wp  <= wp_inc;
          val <= val + 1'b1;
          if (kcnt == bs) begin
            blocks <= blocks + 1'b1;
            kcnt   <= cbff_pkg::BS_W'(1);
          end else begin
            kcnt <= kcnt + 1'b1;
          end
          if (wp_inc == c_end) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          file_count <= file_count + 1'b1;
          res        <= '{status: cbff_pkg::STAT_PLACED,
                          start_word: c[cbff_pkg::START_W-1:0],
                          blocks_used: blocks};
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res.status;
            start_word  <= res.start_word;
            blocks_used <= res.blocks_used;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/contiguous_block_first_fit_core.sv */
// Contiguous first-fit allocator, one request at a time.
// After reset a clearing pass zeroes the word store; in_stall stays high meanwhile.
// Per request: an accept state, then per candidate start a check state and a scan of its words
// (stepping over a busy word block by block), a fill of file_size words, a commit and a result.
// The single word-store port serves scan and fill; a new request is taken only once the result is issued.
// Reset is synchronous, active high; block_size returns to 8, file count to zero.
`default_nettype none

module contiguous_block_first_fit_core #(
  parameter int STORE_WORDS   = cbff_pkg::STORE_WORDS_DEF,
  parameter int TABLE_ENTRIES = cbff_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cbff_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [cbff_pkg::PDATA_W-1:0]   pwdata,
  output logic      [cbff_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cbff_pkg::HANDLE_W-1:0]  file_handle,
  input  wire logic [cbff_pkg::SIZE_W-1:0]    file_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [1:0]                     status,
  output logic      [cbff_pkg::START_W-1:0]   start_word,
  output logic      [cbff_pkg::SIZE_W-1:0]    blocks_used
);

  localparam int AW  = $clog2(STORE_WORDS);
  localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [cbff_pkg::BS_W-1:0]    block_size;
  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic [cbff_pkg::WORD_W-1:0]  mem_wdata;
  logic [cbff_pkg::WORD_W-1:0]  mem_rdata;
  logic                         tab_we;
  logic [TAW-1:0]               tab_addr;
  cbff_pkg::tab_entry_t         tab_wdata;

  cbff_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .block_size (block_size)
  );

  cbff_ram #(
    .WIDTH (cbff_pkg::WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_word_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cbff_ram #(
    .WIDTH ($bits(cbff_pkg::tab_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_file_table (
    .clk   (clk),
    .we    (tab_we),
    .addr  (tab_addr),
    .wdata (tab_wdata),
    .rdata ()
  );

  cbff_engine #(
    .STORE_WORDS   (STORE_WORDS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .block_size  (block_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .file_handle (file_handle),
    .file_size   (file_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .start_word  (start_word),
    .blocks_used (blocks_used),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .tab_we      (tab_we),
    .tab_addr    (tab_addr),
    .tab_wdata   (tab_wdata)
  );

endmodule

`default_nettype wire

/* design/cbff_checker.sv */
// Port-level checks for the contiguous first-fit allocator, bound to the top.
// Depends on cbff_pkg and contiguous_block_first_fit_core.
`default_nettype none

module cbff_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [1:0]                     status,
  input wire logic [cbff_pkg::START_W-1:0]   start_word,
  input wire logic [cbff_pkg::SIZE_W-1:0]    blocks_used
);

  // clearing pass keeps requests out right after reset
  a_reset_busy: assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("block not busy or result shown after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cbff_pkg::STAT_PLACED |->
      start_word == '0 && blocks_used == '0)
    else $error("failed request reports nonzero placement");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == cbff_pkg::STAT_PLACED || status == cbff_pkg::STAT_DISK_FULL ||
                  status == cbff_pkg::STAT_TABLE_FULL)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(start_word) &&
                               $stable(blocks_used))
    else $error("stalled result changed");

endmodule

bind contiguous_block_first_fit_core cbff_checker u_cbff_checker (.*);

`default_nettype wire

/* tb/cbff_placement_checker.sv */
// Checker for the contiguous first-fit allocator: mirrors the word store and file count,
// predicts each placement result and compares it with what the block returns.
// Depends on cbff_pkg for field widths, status codes and the result struct.

module cbff_placement_checker #(
  parameter int STORE_WORDS   = cbff_pkg::STORE_WORDS_DEF,
  parameter int TABLE_ENTRIES = cbff_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cbff_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [cbff_pkg::PDATA_W-1:0]   pwdata,
  input  wire logic                           pready,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [cbff_pkg::HANDLE_W-1:0]  file_handle,
  input  wire logic [cbff_pkg::SIZE_W-1:0]    file_size,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [1:0]                     status,
  input  wire logic [cbff_pkg::START_W-1:0]   start_word,
  input  wire logic [cbff_pkg::SIZE_W-1:0]    blocks_used,
  output int                                  pending,
  output int                                  fails
);
  import cbff_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [WORD_W-1:0] word_mirror [STORE_WORDS];
  logic [BS_W-1:0]   blk_size;
  int                files_placed;
  res_t              placement_q [$];
  int                fail_count = 0;
  int                reported = 0;

  // First-fit placement on the mirrored store; updates the mirror when the file lands.
  function automatic res_t place_file(input logic [HANDLE_W-1:0] h,
                                      input logic [SIZE_W-1:0] sz);
    res_t r;
    int   bs;
    int   s;
    int   i;
    bit   fits;
    r = '0;
    bs = (blk_size == 0) ? 1 : int'(blk_size);
    if (files_placed >= TABLE_ENTRIES) begin
      r.status = STAT_TABLE_FULL;
      return r;
    end
    for (s = 0; s + bs <= STORE_WORDS; s += bs) begin
      // a run past the end of the store never fits
      fits = (s + int'(sz) <= STORE_WORDS);
      for (i = 0; fits && i < int'(sz); i++)
        if (word_mirror[s + i] != '0) fits = 1'b0;
      if (fits) begin
        for (i = 0; i < int'(sz); i++)
          word_mirror[s + i] = WORD_W'(int'(h) + i);
        files_placed++;
        r.status      = STAT_PLACED;
        r.start_word  = START_W'(s);
        r.blocks_used = SIZE_W'((int'(sz) + bs - 1) / bs);
        return r;
      end
    end
    r.status = STAT_DISK_FULL;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    int   k;
    if (rst) begin
      for (k = 0; k < STORE_WORDS; k++) word_mirror[k] = '0;
      files_placed = 0;
      blk_size = BLOCK_SIZE_RST;
      placement_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_BLOCK_SIZE)
        blk_size = pwdata[BS_W-1:0];
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          fail_count++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("unexpected result: status=%0d start=%0d blocks=%0d",
                     status, start_word, blocks_used);
          end
        end else begin
          want = placement_q.pop_front();
          if (status !== want.status || start_word !== want.start_word ||
              blocks_used !== want.blocks_used) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("mismatch: exp status=%0d start=%0d blocks=%0d, got status=%0d start=%0d blocks=%0d",
                       want.status, want.start_word, want.blocks_used,
                       status, start_word, blocks_used);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        placement_q.push_back(place_file(file_handle, file_size));
    end
    pending <= placement_q.size();
    fails   <= fail_count;
  end

endmodule

/* tb/tb_contiguous_block_first_fit_core.sv */
// Top of the allocator testbench: clock, reset, APB block-size writes, add-file requests
// with random gaps and result-side stalls, watchdog and verdict.
// Depends on cbff_pkg, contiguous_block_first_fit_core and cbff_placement_checker.

module tb_contiguous_block_first_fit_core;
  import cbff_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int LONG_HOLD      = 3000;
  localparam int SETTLE         = 50;
  localparam int PHASE_ITEMS    = 80;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [HANDLE_W-1:0] file_handle = '0;
  logic [SIZE_W-1:0]   file_size = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [START_W-1:0]  start_word;
  logic [SIZE_W-1:0]   blocks_used;

  int pending;
  int fails;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_long = 1'b0;

  always #1 clk = ~clk;

  contiguous_block_first_fit_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .file_handle(file_handle),
    .file_size  (file_size),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .start_word (start_word),
    .blocks_used(blocks_used)
  );

  cbff_placement_checker placement_chk (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .file_handle(file_handle),
    .file_size  (file_size),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .start_word (start_word),
    .blocks_used(blocks_used),
    .pending    (pending),
    .fails      (fails)
  );

  task automatic send_request(input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] sz);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    file_handle <= h;
    file_size   <= sz;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    int                  r;
    logic [HANDLE_W-1:0] h;
    logic [SIZE_W-1:0]   sz;
    r = $urandom_range(0, 99);
    if (r < 5) h = '0;
    else if (r < 10) h = '1;
    else h = HANDLE_W'($urandom_range(0, 32767));
    // mostly small files; sizes past the store end are rare
    r = $urandom_range(0, 99);
    if (r < 5) sz = '0;
    else if (r < 70) sz = SIZE_W'($urandom_range(1, 8));
    else if (r < 88) sz = SIZE_W'($urandom_range(9, 40));
    else if (r < 96) sz = SIZE_W'($urandom_range(41, 256));
    else sz = SIZE_W'($urandom_range(257, 511));
    send_request(h, sz);
  endtask

  // drop valid and wait until every request has its result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [BS_W-1:0] bs);
    logic [PDATA_W-1:0] wdata;
    wait_idle();
    wdata = $urandom;
    wdata[BS_W-1:0] = bs;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCK_SIZE, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [BS_W-1:0] bs, input int count);
    reconfigure(bs);
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    repeat (count) send_random();
  endtask

  initial begin : receiver
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_long) begin
        n = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset block size of 8
    send_request(15'h7fff, 9'd1);
    send_request(15'h0000, 9'd8);     // first word holds zero and stays free
    send_request(15'h1234, 9'd0);     // empty file lands at offset 0
    send_request(15'h0001, 9'd9);
    send_request(15'h0003, 9'd257);   // past the store end
    send_request(15'h0003, 9'd511);
    send_request(15'h0004, 9'd256);
    send_request(15'h0000, 9'd1);     // reuses the zero-valued word
    // zero block size acts as one word
    reconfigure(9'd0);
    send_request(15'h0005, 9'd1);
    send_request(15'h7fff, 9'd3);
    send_request(15'h0007, 9'd0);
    // blocks larger than the store leave no candidate start
    reconfigure(9'd511);
    send_request(15'h0009, 9'd1);
    reconfigure(9'd257);
    send_request(15'h0009, 9'd0);
    reconfigure(9'd256);
    send_request(15'h0009, 9'd0);
    send_request(15'h0009, 9'd1);

    // back-pressure: result side holds off while requests keep coming
    reconfigure(9'd1);
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    hold_long = 1'b1;
    repeat (PHASE_ITEMS) send_random();

    run_phase(9'd3, PHASE_ITEMS);
    run_phase(9'd16, PHASE_ITEMS);
    run_phase(9'd2, PHASE_ITEMS);
    run_phase(9'($urandom_range(0, 511)), PHASE_ITEMS);
    run_phase(9'd0, PHASE_ITEMS);
    run_phase(9'd256, 40);
    run_phase(9'($urandom_range(1, 32)), PHASE_ITEMS);
    run_phase(9'd5, PHASE_ITEMS);
    run_phase(9'd1, PHASE_ITEMS);

    // fill the file table with empty files, then table-full answers
    reconfigure(9'd1);
    repeat (270) send_request(15'($urandom_range(0, 32767)), 9'd0);
    reconfigure(9'd511);
    repeat (5) send_random();
    reconfigure(9'd0);
    repeat (5) send_random();

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
